[hw/rtl/lfu_pkg.sv]
// Shared types and constants for the LFU replacement table.
// Used by the front end, the command queue, the engine and the top level.
package lfu_pkg;

	// Defaults for the top-level parameters.
	localparam int unsigned DEF_ENTRIES    = 16;
	localparam int unsigned DEF_DATA_WIDTH = 32;

	// Fixed field widths of the ports.
	localparam int unsigned OP_W      = 2;
	localparam int unsigned SLOT_W    = 4;
	localparam int unsigned PAYLOAD_W = 32;
	localparam int unsigned COUNT_W   = 16;
	localparam int unsigned STAMP_W   = 32;
	localparam int unsigned STATUS_W  = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Operation codes on the op port.
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_HIT    = 2'd1;
	localparam logic [OP_W-1:0] OP_EVICT  = 2'd2;
	localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

	// Status codes on the status port.
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_SLOT  = 2'd3;

	// Command kinds after classification in the front end.
	typedef enum logic [1:0] {
		K_INSERT = 2'd0,
		K_HIT    = 2'd1,
		K_EVICT  = 2'd2,
		K_REJECT = 2'd3
	} cmd_kind_t;

	// One queued command.
	typedef struct packed {
		cmd_kind_t             kind;
		logic [SLOT_W-1:0]     slot;
		logic [PAYLOAD_W-1:0]  payload;
	} cmd_t;

	// One result word.
	typedef struct packed {
		logic [SLOT_W-1:0]     slot;
		logic [PAYLOAD_W-1:0]  payload;
		logic [COUNT_W-1:0]    count;
		logic [STATUS_W-1:0]   status;
	} res_t;

endpackage

[hw/rtl/lfu_front.sv]
// Front end of the LFU table: takes input words and classifies them into commands.
// Depends on lfu_pkg for the command type and the operation codes.
module lfu_front #(
	parameter int unsigned ENTRIES = lfu_pkg::DEF_ENTRIES
) (
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [lfu_pkg::OP_W-1:0]      op,
	input  logic [lfu_pkg::SLOT_W-1:0]    slot,
	input  logic [lfu_pkg::PAYLOAD_W-1:0] payload,
	input  logic                         q_full,
	output logic                         q_push,
	output lfu_pkg::cmd_t                q_cmd
);
	import lfu_pkg::*;

	// A word is taken whenever the queue has room; no-op words are dropped here.
	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full && (op != OP_NOP);

	// Classify the operation; a hit on a slot beyond the table is rejected up front.
	always_comb begin
		q_cmd.slot    = slot;
		q_cmd.payload = payload;
		priority if (op == OP_INSERT) begin
			q_cmd.kind = K_INSERT;
		end else if (op == OP_EVICT) begin
			q_cmd.kind = K_EVICT;
		end else if (32'(slot) >= 32'(ENTRIES)) begin
			q_cmd.kind = K_REJECT;
		end else begin
			q_cmd.kind = K_HIT;
		end
	end

endmodule

[hw/rtl/lfu_cmd_fifo.sv]
// Two-entry command queue between the front end and the engine.
// Depends on lfu_pkg for the command type.
module lfu_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lfu_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output lfu_pkg::cmd_t head
);
	import lfu_pkg::*;

	cmd_t       slots_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head      = slots_q[rd_ptr_q];

	// Storage for the queued commands.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

[hw/rtl/lfu_engine.sv]
// Back end of the LFU table: entry memory, slot scan, hit update and result staging.
// Depends on lfu_pkg for the command and result types and the status codes.
module lfu_engine #(
	parameter int unsigned ENTRIES    = lfu_pkg::DEF_ENTRIES,
	parameter int unsigned DATA_WIDTH = lfu_pkg::DEF_DATA_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  lfu_pkg::cmd_t cmd,
	output logic          cmd_pop,
	output logic          res_valid,
	input  logic          res_ready,
	output lfu_pkg::res_t res
);
	import lfu_pkg::*;

	localparam int unsigned IDX_W     = $clog2(ENTRIES);
	localparam int unsigned STAMP_LSB = DATA_WIDTH;
	localparam int unsigned COUNT_LSB = DATA_WIDTH + STAMP_W;
	localparam int unsigned VALID_POS = DATA_WIDTH + STAMP_W + COUNT_W;
	localparam int unsigned WORD_W    = VALID_POS + 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	typedef enum logic [6:0] {
		S_CLEAR  = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_SCAN   = 7'b0000100,
		S_DRAIN  = 7'b0001000,
		S_HIT_RD = 7'b0010000,
		S_COMMIT = 7'b0100000,
		S_RESP   = 7'b1000000
	} eng_state_t;

	// Wrap-aware age compare: a is older than b when a - b is negative.
	function automatic logic stamp_older(input logic [STAMP_W-1:0] a,
			input logic [STAMP_W-1:0] b);
		logic [STAMP_W-1:0] diff;
		begin
			diff = a - b;
			return diff[STAMP_W-1];
		end
	endfunction

	eng_state_t           state_q;
	cmd_t                 cmd_q;
	logic [IDX_W-1:0]     scan_addr_q;
	logic                 scan_vld_s1;
	logic [IDX_W-1:0]     rd_idx_s1;
	logic [STAMP_W-1:0]   seq_q;
	res_t                 res_q;
	res_t                 res_d;

	logic [WORD_W-1:0]    mem [ENTRIES];
	logic [WORD_W-1:0]    rd_q;
	logic [IDX_W-1:0]     rd_addr;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	logic [WORD_W-1:0]    wr_data;
	logic                 seq_adv;

	// Best eviction candidate and first free slot seen by the scan.
	logic                 best_found_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [COUNT_W-1:0]   best_cnt_q;
	logic [STAMP_W-1:0]   best_stamp_q;
	logic [DATA_WIDTH-1:0] best_data_q;
	logic                 free_found_q;
	logic [IDX_W-1:0]     free_idx_q;

	// Fields of the word that was read last.
	logic                  r_valid;
	logic [COUNT_W-1:0]    r_cnt;
	logic [STAMP_W-1:0]    r_stamp;
	logic [DATA_WIDTH-1:0] r_data;
	logic [COUNT_W-1:0]    hit_cnt;
	logic [IDX_W-1:0]      hit_idx;

	assign r_valid = rd_q[VALID_POS];
	assign r_cnt   = rd_q[VALID_POS-1:COUNT_LSB];
	assign r_stamp = rd_q[COUNT_LSB-1:STAMP_LSB];
	assign r_data  = rd_q[DATA_WIDTH-1:0];
	assign hit_cnt = (r_cnt == COUNT_MAX) ? r_cnt : r_cnt + 16'd1;
	assign hit_idx = IDX_W'(cmd_q.slot);

	assign cmd_pop   = (state_q == S_IDLE) && cmd_valid;
	assign res_valid = (state_q == S_RESP);
	assign res       = res_q;

	// Entry memory: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// Read address: the hit slot in the hit read step, the scan pointer otherwise.
	assign rd_addr = (state_q == S_HIT_RD) ? hit_idx : scan_addr_q;

	// Write port (clearing pass and commit step) and result of the commit step.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = scan_addr_q;
		wr_data = '0;
		seq_adv = 1'b0;
		res_d   = '0;
		if (state_q == S_CLEAR) begin
			wr_en = 1'b1;
		end else if (state_q == S_COMMIT) begin
			unique case (cmd_q.kind)
				K_INSERT: begin
					if (free_found_q) begin
						wr_en   = 1'b1;
						wr_addr = free_idx_q;
						wr_data = {1'b1, 16'd1, seq_q, DATA_WIDTH'(cmd_q.payload)};
						seq_adv = 1'b1;
						res_d.slot  = SLOT_W'(free_idx_q);
						res_d.count = 16'd1;
						res_d.status = ST_OK;
					end else begin
						res_d.status = ST_FULL;
					end
				end
				K_HIT: begin
					if (r_valid) begin
						wr_en   = 1'b1;
						wr_addr = hit_idx;
						wr_data = {1'b1, hit_cnt, seq_q, r_data};
						seq_adv = 1'b1;
						res_d.slot   = cmd_q.slot;
						res_d.count  = hit_cnt;
						res_d.status = ST_OK;
					end else begin
						res_d.slot   = cmd_q.slot;
						res_d.status = ST_BAD_SLOT;
					end
				end
				K_EVICT: begin
					if (best_found_q) begin
						wr_en   = 1'b1;
						wr_addr = best_idx_q;
						wr_data = {1'b0, best_cnt_q, best_stamp_q, best_data_q};
						res_d.slot    = SLOT_W'(best_idx_q);
						res_d.payload = PAYLOAD_W'(best_data_q);
						res_d.count   = best_cnt_q;
						res_d.status  = ST_OK;
					end else begin
						res_d.status = ST_EMPTY;
					end
				end
				K_REJECT: begin
					res_d.slot   = cmd_q.slot;
					res_d.status = ST_BAD_SLOT;
				end
				default: begin
					res_d.status = ST_BAD_SLOT;
				end
			endcase
		end
	end

	// Sequencer: clearing pass, command intake, scan, commit and result hand-off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			scan_addr_q <= '0;
			scan_vld_s1 <= 1'b0;
			seq_q       <= '0;
		end else begin
			scan_vld_s1 <= (state_q == S_SCAN);
			if (seq_adv) begin
				seq_q <= seq_q + 32'd1;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (scan_addr_q == LAST_IDX) begin
						scan_addr_q <= '0;
						state_q     <= S_IDLE;
					end else begin
						scan_addr_q <= scan_addr_q + IDX_W'(1);
					end
				end
				S_IDLE: begin
					scan_addr_q <= '0;
					if (cmd_valid) begin
						unique case (cmd.kind)
							K_INSERT, K_EVICT: state_q <= S_SCAN;
							K_HIT:             state_q <= S_HIT_RD;
							K_REJECT:          state_q <= S_COMMIT;
							default:           state_q <= S_COMMIT;
						endcase
					end
				end
				S_SCAN: begin
					if (scan_addr_q == LAST_IDX) begin
						scan_addr_q <= '0;
						state_q     <= S_DRAIN;
					end else begin
						scan_addr_q <= scan_addr_q + IDX_W'(1);
					end
				end
				S_DRAIN:  state_q <= S_COMMIT;
				S_HIT_RD: state_q <= S_COMMIT;
				S_COMMIT: state_q <= S_RESP;
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	// Command and result holding registers.
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (state_q == S_COMMIT) begin
			res_q <= res_d;
		end
		rd_idx_s1 <= scan_addr_q;
	end

	// Scan step: track the first free slot and the least used, oldest valid entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_found_q <= 1'b0;
			free_found_q <= 1'b0;
		end else if (cmd_pop) begin
			best_found_q <= 1'b0;
			free_found_q <= 1'b0;
		end else if (scan_vld_s1) begin
			if (r_valid) begin
				if (!best_found_q || (r_cnt < best_cnt_q) ||
						((r_cnt == best_cnt_q) && stamp_older(r_stamp, best_stamp_q))) begin
					best_found_q <= 1'b1;
				end
			end else if (!free_found_q) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_vld_s1) begin
			if (r_valid) begin
				if (!best_found_q || (r_cnt < best_cnt_q) ||
						((r_cnt == best_cnt_q) && stamp_older(r_stamp, best_stamp_q))) begin
					best_idx_q   <= rd_idx_s1;
					best_cnt_q   <= r_cnt;
					best_stamp_q <= r_stamp;
					best_data_q  <= r_data;
				end
			end else if (!free_found_q) begin
				free_idx_q <= rd_idx_s1;
			end
		end
	end

	// The stamp counter only moves after a write that leaves a valid entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(seq_q) |-> ($past(wr_en) && $past(wr_data[VALID_POS])))
		else $error("stamp counter advanced without a valid entry write");

	// A successful insert always reports a count of one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && cmd_q.kind == K_INSERT && res_q.status == ST_OK)
		|-> (res_q.count == 16'd1))
		else $error("insert reported a count other than one");

	// An evicted entry always held a nonzero count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && cmd_q.kind == K_EVICT && res_q.status == ST_OK)
		|-> (res_q.count != 16'd0))
		else $error("evicted entry had a zero count");

	// No command is taken during the clearing pass.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !cmd_pop)
		else $error("command taken during the clearing pass");

endmodule

[hw/rtl/lfu_replacement_policy.sv]
// LFU replacement table with oldest-first tie break. Each word is classified on entry
// and queued; the engine then handles one command at a time against an entry memory
// with one write port and one registered read port. An insert or an evict scans every
// slot, one per cycle, then drains, commits and responds; a hit reads its slot, commits
// and responds; an invalid slot commits and responds. After reset the engine runs a
// clearing pass over every entry before it takes its first command; input words are
// still queued meanwhile (up to two). Results leave through an output register, so the
// next command proceeds while a result waits to be taken.
module lfu_replacement_policy #(
	parameter int unsigned ENTRIES    = lfu_pkg::DEF_ENTRIES,
	parameter int unsigned DATA_WIDTH = lfu_pkg::DEF_DATA_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lfu_pkg::OP_W-1:0]       op,
	input  logic [lfu_pkg::SLOT_W-1:0]     slot,
	input  logic [lfu_pkg::PAYLOAD_W-1:0]  payload,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lfu_pkg::SLOT_W-1:0]     slot_out,
	output logic [lfu_pkg::PAYLOAD_W-1:0]  payload_out,
	output logic [lfu_pkg::COUNT_W-1:0]    count_out,
	output logic [lfu_pkg::STATUS_W-1:0]   status
);
	import lfu_pkg::*;

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_not_empty;
	cmd_t q_in;
	cmd_t q_head;
	logic res_valid;
	logic res_ready;
	res_t res;
	logic out_valid_q;
	res_t out_q;

	// Front end: accept and classify.
	lfu_front #(
		.ENTRIES(ENTRIES)
	) u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.slot     (slot),
		.payload  (payload),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_in)
	);

	// Command queue between front end and engine.
	lfu_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// Engine: entry memory and command execution.
	lfu_engine #(
		.ENTRIES    (ENTRIES),
		.DATA_WIDTH (DATA_WIDTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_not_empty),
		.cmd       (q_head),
		.cmd_pop   (q_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register: takes a result whenever it is empty or being drained.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign slot_out    = out_q.slot;
	assign payload_out = out_q.payload;
	assign count_out   = out_q.count;
	assign status      = out_q.status;

endmodule
